/* design/cvsd_speech_decoder_assert.svh */
// ----------------------------------------------------------------------------
// cvsd speech decoder assertion macros
// concurrent assertion wrappers clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef CVSD_SPEECH_DECODER_ASSERT_SVH
`define CVSD_SPEECH_DECODER_ASSERT_SVH
`ifndef ASSERT_OFF
`define CVSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cvsd assertion failed");
`define CVSD_ASSERT_NEXT(lbl, pre, post) \
  `CVSD_ASSERT(lbl, (pre) |=> (post))
`else
`define CVSD_ASSERT(lbl, prop)
`define CVSD_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

/* design/cvsd_pkg.sv */
// ----------------------------------------------------------------------------
// cvsd package
// shared widths, codes, item types and the adaptive step table
// ----------------------------------------------------------------------------
package cvsd_pkg;

  localparam int TimeWidthDefault = 32;
  localparam int NowW             = 32;
  localparam int SampleW          = 8;
  localparam int LevelW           = 7;
  localparam int GainW            = 8;
  localparam int IdleLimitW       = 32;
  localparam int StepW            = 6;
  localparam int AccW             = 11;
  localparam int HistW            = 3;
  localparam int CfgIdxW          = 1;
  localparam int CfgDataW         = 32;

  localparam logic [StepW-1:0]      StepMax        = 6'd63;
  localparam logic [StepW-1:0]      StepSkipFrom   = 6'd12;
  localparam logic signed [AccW-1:0] AccMax        = 11'sd1023;
  localparam logic signed [AccW-1:0] AccMin        = -11'sd1024;
  localparam logic [IdleLimitW-1:0] IdleLimitReset = 32'd50000;

  typedef enum logic [1:0] {
    CMD_DATA       = 2'd0,
    CMD_CLOCK      = 2'd1,
    CMD_DATA_CLOCK = 2'd2
  } cvsd_cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN       = 1'b0,
    CFG_IDLE_LIMIT = 1'b1
  } cvsd_cfg_e;

  typedef struct packed {
    cvsd_cmd_e         cmd;
    logic              bit_value;
    logic [NowW-1:0]   now;
  } cvsd_item_t;

  typedef struct packed {
    logic               emit;
    logic [SampleW-1:0] sample_byte;
  } cvsd_core_t;

  function automatic logic [StepW-1:0] step_size(input logic [StepW-1:0] idx);
    logic [StepW-1:0] val;
    case (idx) inside
      [6'd0:6'd15]:  val = {1'b0, idx[3:0], 1'b1};
      6'd16:         val = 6'd33;
      6'd17:         val = 6'd34;
      6'd18:         val = 6'd36;
      6'd19:         val = 6'd37;
      6'd20:         val = 6'd39;
      6'd21:         val = 6'd40;
      [6'd22:6'd31]: val = idx + 6'd19;
      6'd32:         val = 6'd51;
      6'd33:         val = 6'd52;
      6'd34, 6'd35:  val = 6'd53;
      6'd36, 6'd37:  val = 6'd54;
      [6'd38:6'd40]: val = 6'd55;
      [6'd41:6'd45]: val = 6'd56;
      [6'd46:6'd51]: val = 6'd57;
      [6'd52:6'd56]: val = 6'd58;
      default:       val = 6'd59;
    endcase
    return val;
  endfunction

endpackage

/* design/cvsd_level.sv */
// ----------------------------------------------------------------------------
// cvsd output level
// gain-scaled level: min(s*k*32767/255, 32767) >> 8 with k = 1 + gain/16
// ----------------------------------------------------------------------------
module cvsd_level (
  input  logic [cvsd_pkg::SampleW-1:0] sample_i,
  input  logic [cvsd_pkg::GainW-1:0]   gain_i,
  output logic [cvsd_pkg::LevelW-1:0]  level_o
);
  import cvsd_pkg::*;

  logic [4:0]  k;
  logic [12:0] prod;
  logic [22:0] scaled;
  logic [14:0] coarse;
  logic [14:0] rounded;

  // divide by 65280 as a shift by 8 then a divide by 255 via reciprocal
  always_comb begin
    k       = 5'd1 + {1'b0, gain_i[7:4]};
    prod    = 13'(sample_i) * 13'(k);
    scaled  = {prod[7:0], 15'd0} - 23'(prod[7:0]);
    coarse  = scaled[22:8];
    rounded = coarse + 15'd1 + 15'(coarse[14:8]);
    if (prod >= 13'd255) begin
      level_o = '1;
    end else begin
      level_o = rounded[14:8];
    end
  end

endmodule

/* design/cvsd_core.sv */
// ----------------------------------------------------------------------------
// cvsd decode core
// decoder state, idle check and one decode per rising clock write
// ----------------------------------------------------------------------------
`include "cvsd_speech_decoder_assert.svh"

module cvsd_core #(
  parameter int TIME_WIDTH = cvsd_pkg::TimeWidthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             fire_i,
  input  cvsd_pkg::cvsd_item_t             item_i,
  input  logic [cvsd_pkg::IdleLimitW-1:0]  idle_limit_i,
  output cvsd_pkg::cvsd_core_t             core_o
);
  import cvsd_pkg::*;

  localparam int ExtW = (TIME_WIDTH > IdleLimitW) ? TIME_WIDTH : IdleLimitW;

  logic                   held_q, held_d;
  logic [StepW-1:0]       step_q, step_d;
  logic [HistW-1:0]       hist_q, hist_d;
  logic [TIME_WIDTH-1:0]  last_q, last_d;
  logic signed [AccW-1:0] acc_q, acc_d;

  logic                   is_clk, rise, idle;
  logic [ExtW-1:0]        now_ext;
  logic [TIME_WIDTH-1:0]  now_t, elapsed;
  logic [StepW-1:0]       step_base, step_new, delta;
  logic signed [AccW-1:0] acc_base, acc_new, acc_adj, quot;
  logic signed [AccW:0]   sum;
  logic [HistW-1:0]       hist_new;

  always_comb begin
    held_d = held_q;
    is_clk = 1'b0;
    rise   = 1'b0;
    case (item_i.cmd)
      CMD_DATA: begin
        held_d = item_i.bit_value;
      end
      CMD_CLOCK: begin
        is_clk = 1'b1;
        rise   = item_i.bit_value;
      end
      CMD_DATA_CLOCK: begin
        held_d = item_i.bit_value;
        is_clk = 1'b1;
        rise   = 1'b1;
      end
      default: ;
    endcase

    now_ext   = ExtW'(item_i.now);
    now_t     = now_ext[TIME_WIDTH-1:0];
    elapsed   = now_t - last_q;
    idle      = is_clk && (ExtW'(elapsed) > ExtW'(idle_limit_i));
    step_base = idle ? '0 : step_q;
    acc_base  = idle ? '0 : acc_q;

    hist_new = {hist_q[HistW-2:0], held_d};
    delta    = step_size(step_base);
    if (held_d) begin
      sum = {acc_base[AccW-1], acc_base} + $signed({{(AccW+1-StepW){1'b0}}, delta});
    end else begin
      sum = {acc_base[AccW-1], acc_base} - $signed({{(AccW+1-StepW){1'b0}}, delta});
    end
    if (sum[AccW] != sum[AccW-1]) begin
      acc_new = sum[AccW] ? AccMin : AccMax;
    end else begin
      acc_new = sum[AccW-1:0];
    end

    // a run of three equal bits grows the step, anything else shrinks it unless it is 0 or 12
    if (hist_new == '1 || hist_new == '0) begin
      step_new = (step_base == StepMax) ? StepMax : step_base + 6'd1;
    end else if (step_base == '0 || step_base == StepSkipFrom) begin
      step_new = step_base;
    end else begin
      step_new = step_base - 6'd1;
    end

    // divide by eight rounding toward zero
    acc_adj = acc_new + (acc_new[AccW-1] ? 11'sd7 : 11'sd0);
    quot    = acc_adj >>> 3;

    step_d = step_q;
    acc_d  = acc_q;
    hist_d = hist_q;
    last_d = last_q;
    if (is_clk) begin
      step_d = rise ? step_new : step_base;
      acc_d  = rise ? acc_new : acc_base;
    end
    if (rise) begin
      hist_d = hist_new;
      last_d = now_t;
    end

    core_o.emit        = rise;
    core_o.sample_byte = quot[SampleW-1:0] ^ 8'h80;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      step_q <= '0;
      hist_q <= '0;
      last_q <= '0;
      acc_q  <= '0;
    end else if (fire_i) begin
      held_q <= held_d;
      step_q <= step_d;
      hist_q <= hist_d;
      last_q <= last_d;
      acc_q  <= acc_d;
    end
  end

  `CVSD_ASSERT_NEXT(a_idle_fall_clears, fire_i && idle && !rise, step_q == '0 && acc_q == '0)
  `CVSD_ASSERT_NEXT(a_no_edge_holds, fire_i && !rise, $stable(hist_q) && $stable(last_q))
  `CVSD_ASSERT_NEXT(a_skip_eleven, fire_i && rise && hist_new != '1 && hist_new != '0, step_q != 6'd11)

endmodule

/* design/cvsd_speech_decoder.sv */
// ----------------------------------------------------------------------------
// cvsd speech decoder
// bit-serial continuously variable slope delta decoder with gain-scaled level
// ----------------------------------------------------------------------------
// usage: writes arrive on the s_axis channel, tuser carries the command
// (data write, clock write, data write then rising clock) and tdata the bit
// and the current time count. each rising clock write yields one transaction
// on m_axis with the offset-binary sample and its gain-scaled level; other
// writes update state and yield nothing.
// an accepted write waits in the input register; its result is then loaded into the result register.
// throughput: one write per cycle unless a result waits on a stalled m_axis,
// set by the single decode pass between the input register and the result register.
// configuration (gain, idle limit) goes through the cfg channel, which is
// always ready; write it only while no transaction is in flight.
// reset clears all decoder state, gain to 0 and idle limit to 50000.
// a stalled m_axis holds its result; writes that yield no result keep
// flowing, and a write that yields one waits only while the result register
// is full and not being taken.
// ----------------------------------------------------------------------------
`include "cvsd_speech_decoder_assert.svh"

module cvsd_speech_decoder #(
  parameter int TIME_WIDTH = cvsd_pkg::TimeWidthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [39:0]                    s_axis_tdata,   // bit_value, now[31:0]
  input  logic [1:0]                     s_axis_tuser,   // cmd
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,   // sample_byte, level
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cvsd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cvsd_pkg::CfgDataW-1:0]  cfg_data_i
);
  import cvsd_pkg::*;

  logic                    in_valid_q;
  cvsd_item_t              in_item_q;
  logic                    out_valid_q, out_valid_d;
  logic [SampleW-1:0]      out_sample_q;
  logic [LevelW-1:0]       out_level_q;
  logic [GainW-1:0]        gain_q;
  logic [IdleLimitW-1:0]   idle_limit_q;
  logic                    advance;
  cvsd_core_t              core;
  logic [LevelW-1:0]       level;

  assign advance       = in_valid_q && (!core.emit || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  cvsd_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (advance),
    .item_i       (in_item_q),
    .idle_limit_i (idle_limit_q),
    .core_o       (core)
  );

  cvsd_level u_level (
    .sample_i (core.sample_byte),
    .gain_i   (gain_q),
    .level_o  (level)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q       <= '0;
      idle_limit_q <= IdleLimitReset;
    end else if (cfg_valid_i) begin
      unique case (cvsd_cfg_e'(cfg_index_i))
        CFG_GAIN:       gain_q       <= cfg_data_i[GainW-1:0];
        CFG_IDLE_LIMIT: idle_limit_q <= cfg_data_i[IdleLimitW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.cmd       <= cvsd_cmd_e'(s_axis_tuser);
      in_item_q.bit_value <= s_axis_tdata[0];
      in_item_q.now       <= s_axis_tdata[NowW:1];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && core.emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && core.emit) begin
      out_sample_q <= core.sample_byte;
      out_level_q  <= level;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_level_q, out_sample_q};

  `CVSD_ASSERT(a_out_load, $rose(m_axis_tvalid) |-> $past(advance))
  `CVSD_ASSERT_NEXT(a_in_hold, in_valid_q && !advance, in_valid_q && $stable(in_item_q))
  `CVSD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

/* tb/cvsd_speech_decoder_test.sv */
// ----------------------------------------------------------------------------
// cvsd speech decoder testbench
// drives clock, data and combined writes over the input stream, predicts each
// rising-edge sample and level in a behavioral decoder, and checks every
// result transaction in order under random stalls, register settings,
// idle resets, time wrap and long output backpressure
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cvsd_speech_decoder_test;
  import cvsd_pkg::*;

  localparam int CycleLimit = 400000;
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int unsigned StepTable [0:63] = '{
    1, 3, 5, 7, 9, 11, 13, 15, 17, 19, 21, 23, 25, 27, 29, 31,
    33, 34, 36, 37, 39, 40, 41, 42, 43, 44, 45, 46, 47, 48, 49, 50,
    51, 52, 53, 53, 54, 54, 55, 55, 55, 56, 56, 56, 56, 56, 57, 57,
    57, 57, 57, 57, 58, 58, 58, 58, 58, 59, 59, 59, 59, 59, 59, 59
  };

  typedef struct packed {
    logic [SampleW-1:0] sample_byte;
    logic [LevelW-1:0]  level;
  } decoded_sample_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // decoder state as predicted
  logic [GainW-1:0]      gain_reg = '0;
  logic [IdleLimitW-1:0] idle_limit_reg = IdleLimitReset;
  logic                  held_bit = 1'b0;
  logic [StepW-1:0]      step_pos = '0;
  logic [HistW-1:0]      bit_hist = '0;
  logic [NowW-1:0]       edge_time = '0;
  int                    accum = 0;

  decoded_sample_t pending_samples[$];
  int          errors = 0;
  int unsigned cycle_count = 0;
  int unsigned writes_sent = 0;
  int unsigned samples_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned idle_clears = 0;
  int          hold_cycles = 0;
  bit          no_idle = 1'b0;
  logic        run_bit = 1'b0;

  cvsd_speech_decoder i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d samples outstanding", cycle_count,
               pending_samples.size());
      $display("[cvsd_speech_decoder] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
    errors++;
  endtask

  function automatic logic [LevelW-1:0] scaled_level(input logic [SampleW-1:0] s);
    longint unsigned mult;
    longint unsigned v;
    if (s == 0) return '0;
    mult = 64'(gain_reg >> 4) + 64'd1;
    v = (64'(s) * mult * 64'h7fff) / 64'd255;
    if (v > 64'h7fff) v = 64'h7fff;
    return LevelW'(v >> 8);
  endfunction

  // advances the decoder state for one write, returns 1 when a sample comes out
  function automatic bit decode_write(input logic [1:0] cmd, input logic bit_value,
                                      input logic [NowW-1:0] now,
                                      output decoded_sample_t sample);
    logic            rise;
    logic [NowW-1:0] elapsed;
    int              q;
    sample = '0;
    if (cmd == CMD_DATA) begin
      held_bit = bit_value;
      return 1'b0;
    end
    if (cmd != CMD_CLOCK && cmd != CMD_DATA_CLOCK) return 1'b0;
    if (cmd == CMD_DATA_CLOCK) held_bit = bit_value;
    rise = (cmd == CMD_DATA_CLOCK) || bit_value;
    elapsed = now - edge_time;
    if (elapsed > idle_limit_reg) begin
      step_pos = '0;
      accum = 0;
      idle_clears++;
    end
    if (!rise) return 1'b0;
    bit_hist = {bit_hist[HistW-2:0], held_bit};
    if (held_bit) begin
      accum += int'(StepTable[step_pos]);
      if (accum > 1023) accum = 1023;
    end else begin
      accum -= int'(StepTable[step_pos]);
      if (accum < -1024) accum = -1024;
    end
    if (bit_hist == 3'b111 || bit_hist == 3'b000) begin
      if (step_pos != StepMax) step_pos++;
    end else if (step_pos != 0) begin
      step_pos--;
      if (step_pos == 6'd11) step_pos = StepSkipFrom;
    end
    edge_time = now;
    q = accum / 8;
    sample.sample_byte = SampleW'(q + 128);
    sample.level = scaled_level(sample.sample_byte);
    return 1'b1;
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic send_write(input logic [1:0] cmd, input logic bit_value,
                            input logic [NowW-1:0] now);
    int              gap;
    decoded_sample_t sample;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, now, bit_value};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    writes_sent++;
    if (decode_write(cmd, bit_value, now, sample)) pending_samples.push_back(sample);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input cvsd_cfg_e idx, input logic [CfgDataW-1:0] data);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
    if (idx == CFG_GAIN) gain_reg = data[GainW-1:0];
    else idle_limit_reg = data;
    @(posedge clk_i);
  endtask

  // time stamps mostly inside the idle limit, some right at or past it
  function automatic logic [NowW-1:0] pick_now();
    logic [NowW-1:0] delta;
    case ($urandom_range(0, 9))
      0:       delta = '0;
      1:       delta = idle_limit_reg;
      2:       delta = idle_limit_reg + 1;
      3:       delta = $urandom();
      default: delta = $urandom_range(0, (idle_limit_reg < 3000) ? idle_limit_reg : 3000);
    endcase
    return edge_time + delta;
  endfunction

  task automatic send_random_writes(input int count, input int run_len);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(1, run_len) == 1) run_bit = ~run_bit;
      case ($urandom_range(0, 15))
        0, 1, 2, 3, 4, 5, 6, 7, 8: send_write(CMD_DATA_CLOCK, run_bit, pick_now());
        9, 10, 11: begin
          send_write(CMD_DATA, run_bit, $urandom());
          send_write(CMD_CLOCK, 1'b1, pick_now());
        end
        12: send_write(CMD_CLOCK, 1'b0, pick_now());
        13: send_write(CMD_DATA, 1'($urandom_range(0, 1)), $urandom());
        14: send_write(CMD_CLOCK, 1'b1, pick_now());
        default: send_write(CmdUnused, 1'($urandom_range(0, 1)), $urandom());
      endcase
    end
  endtask

  // result side: random stalls, one long hold when asked, in-order compare
  initial begin
    decoded_sample_t want;
    decoded_sample_t got;
    int              gap;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end else begin
        gap = draw_gap();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.sample_byte = m_axis_tdata[7:0];
      got.level       = m_axis_tdata[14:8];
      if (pending_samples.size() == 0) begin
        report_mismatch("unexpected transaction, sample_byte", 0, 32'(got.sample_byte));
      end else begin
        want = pending_samples.pop_front();
        samples_checked++;
        if (got.sample_byte !== want.sample_byte)
          report_mismatch("sample_byte", 32'(want.sample_byte), 32'(got.sample_byte));
        if (got.level !== want.level)
          report_mismatch("level", 32'(want.level), 32'(got.level));
      end
    end
  end

  task automatic test_directed_cases();
    send_write(CMD_CLOCK, 1'b1, 32'd100);
    send_write(CMD_DATA, 1'b1, 32'd0);
    send_write(CMD_CLOCK, 1'b0, 32'd200);
    send_write(CMD_CLOCK, 1'b1, 32'd300);
    send_write(CMD_DATA_CLOCK, 1'b1, 32'd400);
    send_write(CMD_DATA_CLOCK, 1'b1, 32'd400);
    send_write(CMD_DATA_CLOCK, 1'b1, 32'd401);
    send_write(CmdUnused, 1'b1, 32'hffff_ffff);
    send_write(CmdUnused, 1'b0, 32'h0);
    send_write(CMD_DATA_CLOCK, 1'b0, 32'd50401);
    send_write(CMD_DATA_CLOCK, 1'b0, 32'd100402);
    send_write(CMD_CLOCK, 1'b0, 32'hffff_fff0);
    send_write(CMD_DATA_CLOCK, 1'b1, 32'hffff_fff0);
    send_write(CMD_DATA_CLOCK, 1'b1, 32'h0000_0010);
    send_write(CMD_DATA_CLOCK, 1'b0, 32'h0000_0010);
    send_write(CMD_DATA, 1'b0, 32'h5555_5555);
    send_write(CMD_CLOCK, 1'b1, 32'h0000_0020);
    send_write(CMD_DATA, 1'b1, 32'haaaa_aaaa);
    send_write(CMD_CLOCK, 1'b1, 32'h0000_0020);
    for (int n = 0; n < 5; n++) send_write(CMD_DATA_CLOCK, 1'b0, 32'h0000_0030);
  endtask

  task automatic test_register_extremes();
    write_register(CFG_GAIN, 32'hffff_ffff);
    write_register(CFG_IDLE_LIMIT, 32'h0);
    send_random_writes(100, 12);
    write_register(CFG_GAIN, 32'h0);
    write_register(CFG_IDLE_LIMIT, 32'hffff_ffff);
    send_random_writes(100, 16);
    write_register(CFG_GAIN, $urandom_range(0, 255));
    write_register(CFG_IDLE_LIMIT, $urandom_range(0, 5000));
    send_random_writes(100, 3);
  endtask

  task automatic test_output_backpressure();
    write_register(CFG_IDLE_LIMIT, IdleLimitReset);
    no_idle = 1'b1;
    hold_cycles = 300;
    for (int n = 0; n < 40; n++) begin
      send_write(CMD_DATA_CLOCK, 1'($urandom_range(0, 1)), pick_now());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_sender_pause();
    send_random_writes(30, 6);
    wait_drained();
    send_random_writes(30, 6);
  endtask

  task automatic test_random_stream();
    write_register(CFG_GAIN, $urandom_range(0, 255));
    for (int phase = 0; phase < 6; phase++) begin
      no_idle = (phase == 2);
      send_random_writes(50, $urandom_range(1, 16));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_register_extremes();
    test_output_backpressure();
    test_sender_pause();
    test_random_stream();
    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("covered %0d writes, %0d samples checked, %0d register writes",
             writes_sent, samples_checked, cfg_writes);
    $display("idle clears predicted: %0d, mismatches: %0d", idle_clears, errors);
    if (errors == 0 && pending_samples.size() == 0) begin
      $display("[cvsd_speech_decoder] OK");
    end else begin
      $display("[cvsd_speech_decoder] ERROR");
    end
    $finish;
  end

endmodule
